/* rtl/ntt4bm_pkg.sv */
// shared types and constants for the degree-4 ntt base multiplier
package ntt4bm_pkg;

    typedef logic signed [15:0] coef_t;

    typedef struct packed {
        coef_t coef_a0;
        coef_t coef_a1;
        coef_t coef_a2;
        coef_t coef_a3;
        coef_t coef_b0;
        coef_t coef_b1;
        coef_t coef_b2;
        coef_t coef_b3;
        coef_t twiddle;
    } in_beat_t;

    typedef struct packed {
        coef_t prod_c0;
        coef_t prod_c1;
        coef_t prod_c2;
        coef_t prod_c3;
    } out_beat_t;

    localparam int Q_W = 10;

    localparam logic [Q_W-1:0] Q_SMALL    = 10'd257;
    localparam logic [Q_W-1:0] Q_LARGE    = 10'd769;
    // -255 and -767 taken mod 2^16
    localparam logic [15:0]    QINV_SMALL = 16'hFF01;
    localparam logic [15:0]    QINV_LARGE = 16'hFD01;

    localparam int MONT_STAGES = 3;

endpackage

/* rtl/ntt4bm_mont.sv */
// lanes of three-stage signed montgomery multipliers: x*y*2^-16 mod q, lazily reduced
module ntt4bm_mont #(
    parameter int LANES = 1
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              sel,
    input  logic                              in_vld,
    input  ntt4bm_pkg::coef_t [LANES-1:0]     x,
    input  ntt4bm_pkg::coef_t [LANES-1:0]     y,
    output logic                              out_vld,
    output ntt4bm_pkg::coef_t [LANES-1:0]     z
);
    import ntt4bm_pkg::*;

    logic [MONT_STAGES-1:0] vld_reg;
    logic [MONT_STAGES-1:0] vld_next;

    logic signed [31:0] p1_reg  [LANES];
    logic signed [31:0] p1_next [LANES];
    logic        [31:0] p2_reg  [LANES];
    logic        [15:0] u_reg   [LANES];
    logic        [15:0] u_next  [LANES];
    coef_t              r_reg   [LANES];
    coef_t              r_next  [LANES];

    logic signed [31:0] uq      [LANES];
    logic        [31:0] t       [LANES];

    logic [15:0]    qinv;
    logic [Q_W-1:0] q;

    assign qinv = sel ? QINV_LARGE : QINV_SMALL;
    assign q    = sel ? Q_LARGE : Q_SMALL;

    assign vld_next = {vld_reg[MONT_STAGES-2:0], in_vld};

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            p1_next[i] = $signed(x[i]) * $signed(y[i]);
            // only the low half of the product feeds the quotient digit
            u_next[i]  = 16'(p1_reg[i][15:0] * qinv);
            uq[i]      = $signed(u_reg[i]) * $signed({1'b0, q});
            // low half of t is zero by construction
            t[i]       = p2_reg[i] - uq[i];
            r_next[i]  = t[i][31:16];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                p1_reg[i] <= p1_next[i];
                p2_reg[i] <= p1_reg[i];
                u_reg[i]  <= u_next[i];
                r_reg[i]  <= r_next[i];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            z[i] = r_reg[i];
        end
    end

    assign out_vld = vld_reg[MONT_STAGES-1];

endmodule

/* rtl/ntt4bm_combine.sv */
// karatsuba cross-term combine between the two montgomery levels, one register stage
module ntt4bm_combine (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_vld,
    input  ntt4bm_pkg::coef_t [9:0]     m,
    input  ntt4bm_pkg::coef_t           zeta,
    output logic                        out_vld,
    output ntt4bm_pkg::coef_t [2:0]     mul_x,
    output ntt4bm_pkg::coef_t           mul_z,
    output ntt4bm_pkg::coef_t [3:0]     side
);
    import ntt4bm_pkg::*;

    // lane order: a0b0 a1b1 a2b2 a3b3, then (a1+a3)(b1+b3), (a2+a3)(b2+b3),
    // (a0+a1)(b0+b1), (a0+a2)(b0+b2), (a0+a3)(b0+b3), (a1+a2)(b1+b2)
    logic vld_reg;

    coef_t [2:0] x_reg;
    coef_t [2:0] x_next;
    coef_t       z_reg;
    coef_t [3:0] side_reg;
    coef_t [3:0] side_next;

    always_comb
    begin
        x_next[0] = m[4] - m[1] - m[3] + m[2];
        x_next[1] = m[5] - m[2] - m[3];
        x_next[2] = m[3];
        side_next[0] = m[0];
        side_next[1] = m[6] - m[0] - m[1];
        side_next[2] = m[1] + m[7] - m[0] - m[2];
        side_next[3] = m[8] - m[0] - m[3] + m[9] - m[1] - m[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= x_next;
            z_reg    <= zeta;
            side_reg <= side_next;
        end
    end

    assign out_vld = vld_reg;
    assign mul_x   = x_reg;
    assign mul_z   = z_reg;
    assign side    = side_reg;

endmodule

/* rtl/ntt_degree4_basemul_montgomery_top.sv */
// Degree-4 ntt base multiplier: (a * b) mod (x^4 - zeta) with montgomery reduction.
//
// Input channel in_valid/in_ready/in_data carries one beat: a0..a3, b0..b3 and the
// twiddle zeta in montgomery form. Output channel out_valid/out_ready/out_data
// returns one beat per input beat, in order: four lazily reduced coefficients.
// cfg_we/cfg_data write the modulus select (0: q = 257, 1: q = 769); write it
// only while the pipeline is empty.
// From input accept to out_valid a beat passes two three-stage montgomery
// levels (multiply, quotient digit, subtract), one cross-term combine stage
// between them and one output add stage; one beat per cycle when not stalled.
// The whole pipeline advances together; when out_valid is high and out_ready is
// low every stage holds and in_ready drops, so nothing is lost or repeated.
// Bubbles move down the pipeline with their valid bits cleared.
// Reset clears every valid bit and sets the modulus select to 257.
module ntt_degree4_basemul_montgomery_top (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  ntt4bm_pkg::in_beat_t   in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output ntt4bm_pkg::out_beat_t  out_data,
    input  logic                   cfg_we,
    input  logic                   cfg_data
);
    import ntt4bm_pkg::*;

    logic en;
    logic sel_reg;

    coef_t [9:0] l1_x;
    coef_t [9:0] l1_y;
    coef_t [9:0] l1_z;
    logic        l1_vld;

    coef_t       zeta_d_reg [MONT_STAGES];

    logic        cmb_vld;
    coef_t [2:0] cmb_x;
    coef_t       cmb_z;
    coef_t [3:0] cmb_side;

    coef_t [2:0] l2_y;
    coef_t [2:0] l2_z;
    logic        l2_vld;

    coef_t [3:0] side_d_reg [MONT_STAGES];

    out_beat_t   out_reg;
    out_beat_t   out_next;
    logic        out_vld_reg;

    assign en       = !out_vld_reg || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            sel_reg <= cfg_data;
        end
    end

    // operand lanes for the first montgomery level
    always_comb
    begin
        l1_x[0] = in_data.coef_a0;
        l1_y[0] = in_data.coef_b0;
        l1_x[1] = in_data.coef_a1;
        l1_y[1] = in_data.coef_b1;
        l1_x[2] = in_data.coef_a2;
        l1_y[2] = in_data.coef_b2;
        l1_x[3] = in_data.coef_a3;
        l1_y[3] = in_data.coef_b3;
        l1_x[4] = in_data.coef_a1 + in_data.coef_a3;
        l1_y[4] = in_data.coef_b1 + in_data.coef_b3;
        l1_x[5] = in_data.coef_a2 + in_data.coef_a3;
        l1_y[5] = in_data.coef_b2 + in_data.coef_b3;
        l1_x[6] = in_data.coef_a0 + in_data.coef_a1;
        l1_y[6] = in_data.coef_b0 + in_data.coef_b1;
        l1_x[7] = in_data.coef_a0 + in_data.coef_a2;
        l1_y[7] = in_data.coef_b0 + in_data.coef_b2;
        l1_x[8] = in_data.coef_a0 + in_data.coef_a3;
        l1_y[8] = in_data.coef_b0 + in_data.coef_b3;
        l1_x[9] = in_data.coef_a1 + in_data.coef_a2;
        l1_y[9] = in_data.coef_b1 + in_data.coef_b2;
    end

    ntt4bm_mont #(
        .LANES (10)
    ) u_mont_l1 (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .sel     (sel_reg),
        .in_vld  (in_valid && in_ready),
        .x       (l1_x),
        .y       (l1_y),
        .out_vld (l1_vld),
        .z       (l1_z)
    );

    // twiddle rides alongside the first level
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zeta_d_reg[0] <= in_data.twiddle;
            for (int i = 1; i < MONT_STAGES; i++)
            begin
                zeta_d_reg[i] <= zeta_d_reg[i-1];
            end
        end
    end

    ntt4bm_combine u_combine (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (l1_vld),
        .m       (l1_z),
        .zeta    (zeta_d_reg[MONT_STAGES-1]),
        .out_vld (cmb_vld),
        .mul_x   (cmb_x),
        .mul_z   (cmb_z),
        .side    (cmb_side)
    );

    assign l2_y = {cmb_z, cmb_z, cmb_z};

    ntt4bm_mont #(
        .LANES (3)
    ) u_mont_l2 (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .sel     (sel_reg),
        .in_vld  (cmb_vld),
        .x       (cmb_x),
        .y       (l2_y),
        .out_vld (l2_vld),
        .z       (l2_z)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_d_reg[0] <= cmb_side;
            for (int i = 1; i < MONT_STAGES; i++)
            begin
                side_d_reg[i] <= side_d_reg[i-1];
            end
        end
    end

    always_comb
    begin
        out_next.prod_c0 = l2_z[0] + side_d_reg[MONT_STAGES-1][0];
        out_next.prod_c1 = l2_z[1] + side_d_reg[MONT_STAGES-1][1];
        out_next.prod_c2 = l2_z[2] + side_d_reg[MONT_STAGES-1][2];
        out_next.prod_c3 = side_d_reg[MONT_STAGES-1][3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= l2_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

endmodule

/* rtl/ntt4bm_checker.sv */
// port-level checks for the ntt base multiplier and their bind
module ntt4bm_checker (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_ready,
    input  logic                   out_valid,
    input  logic                   out_ready,
    input  ntt4bm_pkg::out_beat_t  out_data
);
    import ntt4bm_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output beat changed while stalled");

    // backpressure reaches the input while the output is stalled
    a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input accepted during output stall");

    // with no result pending the pipeline must take input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid || out_ready |-> in_ready)
        else $error("input blocked while output is free");

    // an empty pipeline stays empty when nothing enters and nothing stalls
    a_no_invented_beat: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid ##1 !out_valid ##1 !out_valid ##1 !out_valid
        ##1 !out_valid ##1 !out_valid ##1 !out_valid ##1 !out_valid
        ##0 !$past(in_valid, 8) && !$past(in_valid, 7) |=> !out_valid)
        else $error("result beat without a matching input beat");

endmodule

bind ntt_degree4_basemul_montgomery_top ntt4bm_checker u_ntt4bm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
